// ===== sv/tridiagonal_thomas_solver_defines.svh =====
// Assertion macros shared by the checker of the tridiagonal solver.
`ifndef TRIDIAGONAL_THOMAS_SOLVER_DEFINES_SVH
`define TRIDIAGONAL_THOMAS_SOLVER_DEFINES_SVH

// Same-cycle implication, sampled on aclk and idle while aresetn is low.
`define TTS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk and idle while aresetn is low.
`define TTS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/tts_pkg.sv =====
// Package of the tridiagonal solver: widths, limits and the saturation helper.
`timescale 1ns / 1ps
`default_nettype none

package tts_pkg;

    // Fixed-point format Q16.16 on 32 bits.
    localparam int DATA_W      = 32;
    localparam int FRAC_W      = 16;
    localparam int CNT_W       = $clog2(DATA_W);

    // Largest system and the width of a row address.
    localparam int MAX_ROWS    = 64;
    localparam int ROW_W       = $clog2(MAX_ROWS);
    localparam int ROW_INDEX_W = 6;

    // Floor-shifted product and the sum formed from it.
    localparam int PROD_W      = 2 * DATA_W + 1 - FRAC_W;
    localparam int SUM_W       = PROD_W + 1;

    localparam logic [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    // Saturate a two's complement sum to the Q16.16 range.
    function automatic logic [DATA_W-1:0] sat_sum(input logic [SUM_W-1:0] sum);
        logic [SUM_W-DATA_W:0] top;
        top = sum[SUM_W-1:DATA_W-1];
        if (top == '0 || top == '1) begin
            return sum[DATA_W-1:0];
        end
        return sum[SUM_W-1] ? Q_MIN : Q_MAX;
    endfunction

endpackage

`default_nettype wire

// ===== sv/tts_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps
`default_nettype none

module tts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== sv/tts_mul.sv =====
// Bit-serial signed multiplier giving the floor of the product over 2^16.
`timescale 1ns / 1ps
`default_nettype none

module tts_mul import tts_pkg::*; (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                start,
    input  wire logic [DATA_W-1:0]   mcand,
    input  wire logic [DATA_W-1:0]   mplier,
    output logic                     done,
    output logic      [PROD_W-1:0]   prod
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DATA_W-1:0] mcand_reg, mcand_next;
    logic [DATA_W:0]   hi_reg, hi_next;
    logic [DATA_W-1:0] lo_reg, lo_next;

    logic [DATA_W+1:0] mcand_ext;
    logic [DATA_W+1:0] addend;
    logic [DATA_W+1:0] sum;
    logic              last_step;

    // One multiplier bit per cycle; the sign bit carries weight -2^31, so it subtracts.
    always_comb begin
        last_step  = (cnt_reg == CNT_W'(DATA_W - 1));
        mcand_ext  = {{2{mcand_reg[DATA_W-1]}}, mcand_reg};
        if (!lo_reg[0]) begin
            addend = '0;
        end else if (last_step) begin
            addend = -mcand_ext;
        end else begin
            addend = mcand_ext;
        end
        sum = {hi_reg[DATA_W], hi_reg} + addend;

        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        mcand_next = mcand_reg;
        hi_next    = hi_reg;
        lo_next    = lo_reg;

        if (start) begin
            busy_next  = 1'b1;
            cnt_next   = '0;
            mcand_next = mcand;
            hi_next    = '0;
            lo_next    = mplier;
        end else if (busy_reg) begin
            hi_next  = sum[DATA_W+1:1];
            lo_next  = {sum[0], lo_reg[DATA_W-1:1]};
            cnt_next = cnt_reg + 1'b1;
            if (last_step) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Datapath shift registers.
    always_ff @(posedge aclk) begin
        cnt_reg   <= cnt_next;
        mcand_reg <= mcand_next;
        hi_reg    <= hi_next;
        lo_reg    <= lo_next;
    end

    assign done = done_reg;
    assign prod = {hi_reg, lo_reg[DATA_W-1:FRAC_W]};

endmodule

`default_nettype wire

// ===== sv/tts_div.sv =====
// Radix-2 restoring divider for (num * 2^16) / den, truncated and saturated.
`timescale 1ns / 1ps
`default_nettype none

module tts_div import tts_pkg::*; (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                start,
    input  wire logic [DATA_W-1:0]   num_mag,
    input  wire logic                num_neg,
    input  wire logic [DATA_W-1:0]   den,
    output logic                     done,
    output logic      [DATA_W-1:0]   quotient
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DATA_W-1:0] dmag_reg, dmag_next;
    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] sh_reg, sh_next;
    logic              neg_reg, neg_next;
    logic              ovf_reg, ovf_next;

    logic [DATA_W-1:0] den_mag;
    logic [DATA_W:0]   trial;
    logic              fits;

    // The scaled numerator has 48 bits; its top part must stay below the divisor
    // for the quotient to fit 32 bits, otherwise the result saturates.
    always_comb begin
        den_mag = den[DATA_W-1] ? -den : den;
        trial   = {rem_reg, sh_reg[DATA_W-1]};
        fits    = (trial >= {1'b0, dmag_reg});

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dmag_next = dmag_reg;
        rem_next  = rem_reg;
        sh_next   = sh_reg;
        neg_next  = neg_reg;
        ovf_next  = ovf_reg;

        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dmag_next = den_mag;
            rem_next  = num_mag >> (DATA_W - FRAC_W);
            sh_next   = num_mag << FRAC_W;
            neg_next  = num_neg ^ den[DATA_W-1];
            ovf_next  = ((num_mag >> (DATA_W - FRAC_W)) >= den_mag);
        end else if (busy_reg) begin
            rem_next = fits ? DATA_W'(trial - {1'b0, dmag_reg}) : trial[DATA_W-1:0];
            sh_next  = {sh_reg[DATA_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DATA_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Sign and saturation of the finished magnitude.
    always_comb begin
        if (!neg_reg) begin
            quotient = (ovf_reg || sh_reg[DATA_W-1]) ? Q_MAX : sh_reg;
        end else begin
            quotient = (ovf_reg || sh_reg > Q_MIN) ? Q_MIN : -sh_reg;
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        cnt_reg  <= cnt_next;
        dmag_reg <= dmag_next;
        rem_reg  <= rem_next;
        sh_reg   <= sh_next;
        neg_reg  <= neg_next;
        ovf_reg  <= ovf_next;
    end

    assign done = done_reg;

endmodule

`default_nettype wire

// ===== sv/tridiagonal_thomas_solver.sv =====
// Top level of the tridiagonal system solver (Thomas algorithm, Q16.16).
`timescale 1ns / 1ps
`default_nettype none

// One row of the system is taken per input transfer: sub-diagonal, diagonal,
// super-diagonal and right-hand side, all signed Q16.16. The row with s_last_row
// set (or the 64th row) closes the system, after which the solutions come out
// from the last row down to row 0, the final one marked by m_last_result. For
// each row, two bit-serial multipliers form the denominator and numerator side
// by side, the ST_FCHK state checks the denominator, two radix-2 dividers run
// side by side, and the row's P and Q are stored before the block is ready again.
// A row with a zero denominator skips the dividers. Each solution after the first
// comes from one read of the coefficient RAMs and the bit-serial multiplier of
// the back substitution; a stalled result holds the next one back for as long
// as the stall lasts.
// A zero denominator makes every solution of that system 0 with m_singular set.
// The next system may be sent while the last solution is still waiting.
module tridiagonal_thomas_solver import tts_pkg::*; (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic signed [DATA_W-1:0]      s_sub_diagonal,
    input  wire logic signed [DATA_W-1:0]      s_main_diagonal,
    input  wire logic signed [DATA_W-1:0]      s_super_diagonal,
    input  wire logic signed [DATA_W-1:0]      s_right_side,
    input  wire logic                          s_last_row,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic             [ROW_INDEX_W-1:0] m_row_index,
    output logic signed      [DATA_W-1:0]      m_solution,
    output logic                               m_singular,
    output logic                               m_last_result
);

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_FMUL   = 8'b0000_0010,
        ST_FCHK   = 8'b0000_0100,
        ST_FDIV   = 8'b0000_1000,
        ST_BREAD  = 8'b0001_0000,
        ST_BSTART = 8'b0010_0000,
        ST_BMUL   = 8'b0100_0000,
        ST_BEMIT  = 8'b1000_0000
    } state_t;

    state_t            state_reg, state_next;
    logic [ROW_W-1:0]  row_cnt_reg, row_cnt_next;
    logic [DATA_W-1:0] prev_p_reg, prev_p_next;
    logic [DATA_W-1:0] prev_q_reg, prev_q_next;
    logic              singular_reg, singular_next;
    logic              m_valid_reg, m_valid_next;

    logic [ROW_W-1:0]       idx_reg, idx_next;
    logic                   last_reg, last_next;
    logic [DATA_W-1:0]      d_reg, d_next;
    logic [DATA_W-1:0]      c_reg, c_next;
    logic [DATA_W-1:0]      r_reg, r_next;
    logic [DATA_W-1:0]      den_reg, den_next;
    logic [DATA_W-1:0]      nq_reg, nq_next;
    logic [DATA_W-1:0]      x_reg, x_next;
    logic [ROW_W-1:0]       bidx_reg, bidx_next;
    logic [ROW_INDEX_W-1:0] m_row_index_reg, m_row_index_next;
    logic [DATA_W-1:0]      m_solution_reg, m_solution_next;
    logic                   m_singular_reg, m_singular_next;
    logic                   m_last_result_reg, m_last_result_next;

    logic              s_accept;
    logic              wrap;
    logic [ROW_W-1:0]  in_idx;
    logic              in_last;
    logic [DATA_W-1:0] in_sub;

    logic              mul0_start, mul0_done, mul1_done;
    logic [DATA_W-1:0] mul0_mcand, mul0_mplier;
    logic [PROD_W-1:0] mul0_prod, mul1_prod;

    logic              div_start, div0_done, div1_done;
    logic [DATA_W-1:0] div0_mag, div1_mag;
    logic              div0_neg;
    logic [DATA_W-1:0] div0_quot, div1_quot;

    logic              commit;
    logic [DATA_W-1:0] p_val, q_val;
    logic [DATA_W-1:0] ram_p_rdata, ram_q_rdata;
    logic              out_free;

    // Input transfer and the row-level special cases.
    assign s_ready  = (state_reg == ST_IDLE);
    assign s_accept = s_valid && s_ready;
    assign wrap     = (row_cnt_reg >= ROW_W'(MAX_ROWS - 1));
    assign in_idx   = wrap ? ROW_W'(MAX_ROWS - 1) : row_cnt_reg;
    assign in_last  = s_last_row || wrap;
    assign in_sub   = (in_idx == '0) ? '0 : s_sub_diagonal;

    // Multiplier 0 serves a*P in the sweep and P*x in back substitution.
    assign mul0_start  = s_accept || (state_reg == ST_BSTART);
    assign mul0_mcand  = (state_reg == ST_BSTART) ? ram_p_rdata : in_sub;
    assign mul0_mplier = (state_reg == ST_BSTART) ? x_reg : prev_p_reg;

    tts_mul u_mul0 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul0_start),
        .mcand   (mul0_mcand),
        .mplier  (mul0_mplier),
        .done    (mul0_done),
        .prod    (mul0_prod)
    );

    tts_mul u_mul1 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (s_accept),
        .mcand   (in_sub),
        .mplier  (prev_q_reg),
        .done    (mul1_done),
        .prod    (mul1_prod)
    );

    // Dividers for P = -c / den and Q = nq / den.
    assign div0_mag = c_reg[DATA_W-1] ? -c_reg : c_reg;
    assign div0_neg = !c_reg[DATA_W-1] && (c_reg != '0);
    assign div1_mag = nq_reg[DATA_W-1] ? -nq_reg : nq_reg;

    tts_div u_div0 (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .num_mag  (div0_mag),
        .num_neg  (div0_neg),
        .den      (den_reg),
        .done     (div0_done),
        .quotient (div0_quot)
    );

    tts_div u_div1 (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .num_mag  (div1_mag),
        .num_neg  (nq_reg[DATA_W-1]),
        .den      (den_reg),
        .done     (div1_done),
        .quotient (div1_quot)
    );

    // Stores of the sweep coefficients P and Q.
    tts_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ROWS)) u_ratio_ram (
        .aclk    (aclk),
        .wr_en   (commit),
        .wr_addr (idx_reg),
        .wr_data (p_val),
        .rd_en   (state_reg == ST_BREAD),
        .rd_addr (bidx_reg),
        .rd_data (ram_p_rdata)
    );

    tts_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ROWS)) u_offset_ram (
        .aclk    (aclk),
        .wr_en   (commit),
        .wr_addr (idx_reg),
        .wr_data (q_val),
        .rd_en   (state_reg == ST_BREAD),
        .rd_addr (bidx_reg),
        .rd_data (ram_q_rdata)
    );

    assign out_free = !m_valid_reg || m_ready;

    // Sequencer of the forward sweep and the back substitution.
    always_comb begin
        state_next         = state_reg;
        row_cnt_next       = row_cnt_reg;
        prev_p_next        = prev_p_reg;
        prev_q_next        = prev_q_reg;
        singular_next      = singular_reg;
        m_valid_next       = m_valid_reg && !m_ready;
        idx_next           = idx_reg;
        last_next          = last_reg;
        d_next             = d_reg;
        c_next             = c_reg;
        r_next             = r_reg;
        den_next           = den_reg;
        nq_next            = nq_reg;
        x_next             = x_reg;
        bidx_next          = bidx_reg;
        m_row_index_next   = m_row_index_reg;
        m_solution_next    = m_solution_reg;
        m_singular_next    = m_singular_reg;
        m_last_result_next = m_last_result_reg;
        div_start          = 1'b0;
        commit             = 1'b0;
        p_val              = '0;
        q_val              = '0;

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    idx_next   = in_idx;
                    last_next  = in_last;
                    d_next     = s_main_diagonal;
                    c_next     = in_last ? '0 : s_super_diagonal;
                    r_next     = s_right_side;
                    state_next = ST_FMUL;
                end
            end
            ST_FMUL: begin
                if (mul0_done && mul1_done) begin
                    den_next = sat_sum({{(SUM_W-DATA_W){d_reg[DATA_W-1]}}, d_reg}
                                       + {mul0_prod[PROD_W-1], mul0_prod});
                    nq_next  = sat_sum({{(SUM_W-DATA_W){r_reg[DATA_W-1]}}, r_reg}
                                       - {mul1_prod[PROD_W-1], mul1_prod});
                    state_next = ST_FCHK;
                end
            end
            ST_FCHK: begin
                // A zero denominator stores P and Q as zero and marks the system.
                if (den_reg == '0) begin
                    commit        = 1'b1;
                    singular_next = 1'b1;
                end else begin
                    div_start  = 1'b1;
                    state_next = ST_FDIV;
                end
            end
            ST_FDIV: begin
                if (div0_done && div1_done) begin
                    commit = 1'b1;
                    p_val  = div0_quot;
                    q_val  = div1_quot;
                end
            end
            ST_BREAD: begin
                state_next = ST_BSTART;
            end
            ST_BSTART: begin
                state_next = ST_BMUL;
            end
            ST_BMUL: begin
                if (mul0_done) begin
                    x_next = sat_sum({mul0_prod[PROD_W-1], mul0_prod}
                                     + {{(SUM_W-DATA_W){ram_q_rdata[DATA_W-1]}}, ram_q_rdata});
                    state_next = ST_BEMIT;
                end
            end
            ST_BEMIT: begin
                if (out_free) begin
                    m_valid_next       = 1'b1;
                    m_row_index_next   = ROW_INDEX_W'(bidx_reg);
                    m_solution_next    = singular_reg ? '0 : x_reg;
                    m_singular_next    = singular_reg;
                    m_last_result_next = (bidx_reg == '0);
                    if (bidx_reg == '0) begin
                        // Run complete: clear the sweep state for the next system.
                        row_cnt_next  = '0;
                        prev_p_next   = '0;
                        prev_q_next   = '0;
                        singular_next = 1'b0;
                        state_next    = ST_IDLE;
                    end else begin
                        bidx_next  = bidx_reg - 1'b1;
                        state_next = ST_BREAD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // Store the row's coefficients and either wait for the next row or
        // start back substitution, whose first solution is Q of the last row.
        if (commit) begin
            prev_p_next = p_val;
            prev_q_next = q_val;
            if (last_reg) begin
                x_next     = q_val;
                bidx_next  = idx_reg;
                state_next = ST_BEMIT;
            end else begin
                row_cnt_next = idx_reg + 1'b1;
                state_next   = ST_IDLE;
            end
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            row_cnt_reg  <= '0;
            prev_p_reg   <= '0;
            prev_q_reg   <= '0;
            singular_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            row_cnt_reg  <= row_cnt_next;
            prev_p_reg   <= prev_p_next;
            prev_q_reg   <= prev_q_next;
            singular_reg <= singular_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Row operands, intermediate values and the output register.
    always_ff @(posedge aclk) begin
        idx_reg           <= idx_next;
        last_reg          <= last_next;
        d_reg             <= d_next;
        c_reg             <= c_next;
        r_reg             <= r_next;
        den_reg           <= den_next;
        nq_reg            <= nq_next;
        x_reg             <= x_next;
        bidx_reg          <= bidx_next;
        m_row_index_reg   <= m_row_index_next;
        m_solution_reg    <= m_solution_next;
        m_singular_reg    <= m_singular_next;
        m_last_result_reg <= m_last_result_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_row_index   = m_row_index_reg;
    assign m_solution    = m_solution_reg;
    assign m_singular    = m_singular_reg;
    assign m_last_result = m_last_result_reg;

endmodule

`default_nettype wire

// ===== sv/tts_checker.sv =====
// Port-level checker of the tridiagonal solver and its binding to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "tridiagonal_thomas_solver_defines.svh"

module tts_checker import tts_pkg::*; (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_valid,
    input wire logic                          s_ready,
    input wire logic                          m_valid,
    input wire logic                          m_ready,
    input wire logic        [ROW_INDEX_W-1:0] m_row_index,
    input wire logic signed [DATA_W-1:0]      m_solution,
    input wire logic                          m_singular,
    input wire logic                          m_last_result
);

    // The final solution of a run is always the one for row zero.
    `TTS_ASSERT_SAME(a_last_is_row_zero, m_valid, m_last_result == (m_row_index == '0), "last_result does not match row zero")

    // A singular system reports only zero solutions.
    `TTS_ASSERT_SAME(a_singular_zero, m_valid && m_singular, m_solution == '0, "nonzero solution for a singular system")

    // A row transfer makes the block busy, so no second row is taken straight after it.
    `TTS_ASSERT_NEXT(a_busy_after_row, s_valid && s_ready, !s_ready, "row taken on two consecutive cycles")

    // A stalled result stays put until it is taken.
    `TTS_ASSERT_NEXT(a_result_held, m_valid && !m_ready, m_valid && $stable(m_solution) && $stable(m_row_index), "stalled result changed")

endmodule

bind tridiagonal_thomas_solver tts_checker u_checker (.*);

`default_nettype wire
